### src/usg_pkg.sv
package usg_pkg;

	// Grid and CORDIC configuration.
	localparam int MAX_SEGMENTS    = 255;
	localparam int CORDIC_STAGES   = 16;
	localparam int ANGLE_TABLE_LEN = 24;
	localparam int CORDIC_ITERS    = (CORDIC_STAGES > ANGLE_TABLE_LEN) ?
		ANGLE_TABLE_LEN : CORDIC_STAGES;

	// Divider: four quotient bits per stage over a 32-bit fraction.
	localparam int DIV_BITS   = 4;
	localparam int DIV_WIDTH  = 32;
	localparam int DIV_STAGES = DIV_WIDTH / DIV_BITS;

	// Product and rounding stages after the CORDIC.
	localparam int MUL_STAGES = 4;

	// Pipeline length from the input register to the result register.
	localparam int TOTAL_STAGES = 1 + DIV_STAGES + CORDIC_ITERS + 1 + MUL_STAGES;
	// Sideband delay from divider output to the result.
	localparam int TAIL_STAGES  = CORDIC_ITERS + 1 + MUL_STAGES;

	// Register indexes of the configuration port.
	localparam logic [7:0] REG_RADIUS   = 8'd0;
	localparam logic [7:0] REG_SEGMENTS = 8'd1;

	localparam logic [23:0] RADIUS_RESET   = 24'd12800;
	localparam logic [7:0]  SEGMENTS_RESET = 8'd20;

	// Fixed-point constants.
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
	localparam logic signed [27:0] POS_LIMIT   = 28'sd16777215;
	localparam logic signed [16:0] NORM_LIMIT  = 17'sd32767;

	// Sideband carried beside the divider.
	typedef struct packed {
		logic        lat_eq;
		logic        lon_eq;
		logic [15:0] upper;
		logic [16:0] lower;
		logic        quad;
	} usg_head_t;

	// Sideband carried beside the CORDIC and the multipliers.
	typedef struct packed {
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		logic [15:0] upper;
		logic [16:0] lower;
		logic        quad;
	} usg_tail_t;

	// Arctangent of 2^-i as a fraction of a full turn.
	function automatic logic [29:0] atan_turn(input int idx);
		logic [29:0] a;
		unique case (idx)
			0:  a = 30'h20000000;
			1:  a = 30'h12E4051D;
			2:  a = 30'h09FB385B;
			3:  a = 30'h051111D4;
			4:  a = 30'h028B0D43;
			5:  a = 30'h0145D7E1;
			6:  a = 30'h00A2F61E;
			7:  a = 30'h00517C55;
			8:  a = 30'h0028BE53;
			9:  a = 30'h00145F2E;
			10: a = 30'h000A2F98;
			11: a = 30'h000517CC;
			12: a = 30'h00028BE6;
			13: a = 30'h000145F3;
			14: a = 30'h0000A2F9;
			15: a = 30'h0000517C;
			16: a = 30'h000028BE;
			17: a = 30'h0000145F;
			18: a = 30'h00000A2F;
			19: a = 30'h00000517;
			20: a = 30'h0000028B;
			21: a = 30'h00000145;
			22: a = 30'h000000A2;
			23: a = 30'h00000051;
			default: a = 30'h0;
		endcase
		return a;
	endfunction

	// Four restoring division steps: returns {remainder, quotient bits}.
	function automatic logic [11:0] div_step(input logic [7:0] rem,
		input logic [3:0] bits, input logic [7:0] seg);
		logic [8:0] t;
		logic [7:0] r;
		logic [3:0] q;
		r = rem;
		for (int k = 3; k >= 0; k--) begin
			t = {r, bits[k]};
			if (t >= {1'b0, seg}) begin
				q[k] = 1'b1;
				t = t - {1'b0, seg};
			end else begin
				q[k] = 1'b0;
			end
			r = t[7:0];
		end
		return {r, q};
	endfunction

endpackage

### src/uv_sphere_vertex_generator.sv
// UV sphere vertex generator.
// A grid point (lat_step, lon_step) is transferred in at a rising edge with
// start high and busy low. busy is always low: the block takes one point in
// every cycle, with any number of points in flight.
// Each result is shown for one cycle with done high and is transferred out
// at the edge that ends that cycle. A point passes through the input stage,
// the 8-stage angle divider, one CORDIC stage per iteration, a quadrant
// stage and four product and rounding stages before its result is shown.
// Results leave in input order; the receiver cannot stall, so nothing backs
// up inside the pipeline.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// must only be made while no point is in flight. Index 0 is the radius,
// index 1 the segment count; other indexes are ignored.
// Reset clears the pipeline valid bits and loads radius 50.0 and 20
// segments; no result is presented until a new point enters.
module uv_sphere_vertex_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [7:0]         lat_step,
	input  logic [7:0]         lon_step,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	output logic               done,
	output logic signed [24:0] pos_x,
	output logic signed [24:0] pos_y,
	output logic signed [24:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic [15:0]        upper_index,
	output logic [16:0]        lower_index,
	output logic               quad_valid
);

	logic [23:0] radius_q;
	logic [7:0]  seg_q;
	logic [7:0]  seg_eff;
	logic [usg_pkg::TOTAL_STAGES-1:0] vld_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= usg_pkg::RADIUS_RESET;
			seg_q    <= usg_pkg::SEGMENTS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == usg_pkg::REG_RADIUS) begin
				radius_q <= cfg_data;
			end else if (cfg_index == usg_pkg::REG_SEGMENTS) begin
				seg_q <= cfg_data[7:0];
			end
		end
	end

	// Zero segments act as one; the count is limited to the maximum.
	always_comb begin
		if (seg_q == 8'd0) begin
			seg_eff = 8'd1;
		end else if (32'(seg_q) > usg_pkg::MAX_SEGMENTS) begin
			seg_eff = 8'(usg_pkg::MAX_SEGMENTS);
		end else begin
			seg_eff = seg_q;
		end
	end

	assign busy = 1'b0;

	// Valid bits travel beside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[usg_pkg::TOTAL_STAGES-2:0], start};
		end
	end

	// Input stage: clamp both steps to the grid.
	logic [7:0] lat_s1;
	logic [7:0] lon_s1;

	always_ff @(posedge clk) begin
		lat_s1 <= (lat_step > seg_eff) ? seg_eff : lat_step;
		lon_s1 <= (lon_step > seg_eff) ? seg_eff : lon_step;
	end

	logic        lat_eq;
	logic        lon_eq;
	logic [7:0]  lat_mod;
	logic [7:0]  lon_mod;
	logic [7:0]  half_seg;
	logic [16:0] upper_full;
	usg_pkg::usg_head_t head;

	assign lat_eq   = (lat_s1 == seg_eff);
	assign lon_eq   = (lon_s1 == seg_eff);
	assign lat_mod  = lat_eq ? 8'd0 : lat_s1;
	assign lon_mod  = lon_eq ? 8'd0 : lon_s1;
	assign half_seg = {1'b0, seg_eff[7:1]};

	// Vertex indices of the upper and lower row of the quad.
	assign upper_full   = 17'(lat_s1) * (17'(seg_eff) + 17'd1) + 17'(lon_s1);
	assign head.lat_eq  = lat_eq;
	assign head.lon_eq  = lon_eq;
	assign head.upper   = upper_full[15:0];
	assign head.lower   = 17'(upper_full[15:0]) + 17'(seg_eff) + 17'd1;
	assign head.quad    = (lat_s1 < seg_eff) && (lon_s1 < seg_eff);

	// Angles and texture coordinates as rounded fractions of the step.
	logic [31:0] q_theta;
	logic [31:0] q_phi;
	logic [31:0] q_u;
	logic [31:0] q_v;

	usg_div u_div_theta (
		.clk    (clk),
		.seg    (seg_eff),
		.rem_in ({1'b0, lat_mod[7:1]}),
		.num_in ({lat_mod[0], 23'b0, half_seg}),
		.quot   (q_theta)
	);

	usg_div u_div_phi (
		.clk    (clk),
		.seg    (seg_eff),
		.rem_in (lon_mod),
		.num_in ({24'b0, half_seg}),
		.quot   (q_phi)
	);

	usg_div u_div_u (
		.clk    (clk),
		.seg    (seg_eff),
		.rem_in (8'd0),
		.num_in ({8'b0, lon_mod, 8'b0, half_seg}),
		.quot   (q_u)
	);

	usg_div u_div_v (
		.clk    (clk),
		.seg    (seg_eff),
		.rem_in (8'd0),
		.num_in ({8'b0, lat_mod, 8'b0, half_seg}),
		.quot   (q_v)
	);

	// Sideband delay matching the divider.
	usg_pkg::usg_head_t head_s [usg_pkg::DIV_STAGES];

	for (genvar k = 0; k < usg_pkg::DIV_STAGES; k++) begin : g_head
		always_ff @(posedge clk) begin
			if (k == 0) begin
				head_s[k] <= head;
			end else begin
				head_s[k] <= head_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	usg_pkg::usg_head_t head_d;
	usg_pkg::usg_tail_t tail;
	logic [31:0] theta;

	assign head_d     = head_s[usg_pkg::DIV_STAGES-1];
	assign theta      = {head_d.lat_eq, q_theta[30:0]};
	assign tail.tex_u = {head_d.lon_eq, q_u[15:0]};
	assign tail.tex_v = {head_d.lat_eq, q_v[15:0]};
	assign tail.upper = head_d.upper;
	assign tail.lower = head_d.lower;
	assign tail.quad  = head_d.quad;

	// Sine and cosine of both angles.
	logic signed [31:0] cos_t;
	logic signed [31:0] sin_t;
	logic signed [31:0] cos_p;
	logic signed [31:0] sin_p;

	usg_cordic u_cordic_theta (
		.clk   (clk),
		.angle (theta),
		.cos_v (cos_t),
		.sin_v (sin_t)
	);

	usg_cordic u_cordic_phi (
		.clk   (clk),
		.angle (q_phi),
		.cos_v (cos_p),
		.sin_v (sin_p)
	);

	usg_mul u_mul (
		.clk    (clk),
		.radius (radius_q),
		.cos_t  (cos_t),
		.sin_t  (sin_t),
		.cos_p  (cos_p),
		.sin_p  (sin_p),
		.pos_x  (pos_x),
		.pos_y  (pos_y),
		.pos_z  (pos_z),
		.norm_x (norm_x),
		.norm_y (norm_y),
		.norm_z (norm_z)
	);

	// Sideband delay matching the CORDIC and the multipliers.
	usg_pkg::usg_tail_t tail_s [usg_pkg::TAIL_STAGES];

	for (genvar k = 0; k < usg_pkg::TAIL_STAGES; k++) begin : g_tail
		always_ff @(posedge clk) begin
			if (k == 0) begin
				tail_s[k] <= tail;
			end else begin
				tail_s[k] <= tail_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign done        = vld_q[usg_pkg::TOTAL_STAGES-1];
	assign tex_u       = tail_s[usg_pkg::TAIL_STAGES-1].tex_u;
	assign tex_v       = tail_s[usg_pkg::TAIL_STAGES-1].tex_v;
	assign upper_index = tail_s[usg_pkg::TAIL_STAGES-1].upper;
	assign lower_index = tail_s[usg_pkg::TAIL_STAGES-1].lower;
	assign quad_valid  = tail_s[usg_pkg::TAIL_STAGES-1].quad;

	// The normal is saturated symmetrically.
	a_norm_x: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> norm_x != -16'sd32768)
		else $error("norm_x outside the saturated range");

	a_norm_y: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> norm_y != -16'sd32768)
		else $error("norm_y outside the saturated range");

	// A valid bit in the last stage but one must reach the result strobe.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[usg_pkg::TOTAL_STAGES-2] |=> done)
		else $error("result strobe lost in the pipeline");

endmodule

### src/usg_div.sv
// Pipelined restoring divider: quotient of {rem_in, num_in} by seg, where
// rem_in is below seg. Four quotient bits are resolved in each stage.
module usg_div (
	input  logic        clk,
	input  logic [7:0]  seg,
	input  logic [7:0]  rem_in,
	input  logic [31:0] num_in,
	output logic [31:0] quot
);

	logic [7:0]  rem_s  [usg_pkg::DIV_STAGES];
	logic [31:0] num_s  [usg_pkg::DIV_STAGES];
	logic [31:0] quot_s [usg_pkg::DIV_STAGES];

	for (genvar k = 0; k < usg_pkg::DIV_STAGES; k++) begin : g_stage
		logic [7:0]  rem_prev;
		logic [31:0] num_prev;
		logic [31:0] quot_prev;
		logic [11:0] step;

		if (k == 0) begin : g_first
			assign rem_prev  = rem_in;
			assign num_prev  = num_in;
			assign quot_prev = '0;
		end else begin : g_next
			assign rem_prev  = rem_s[k-1];
			assign num_prev  = num_s[k-1];
			assign quot_prev = quot_s[k-1];
		end

		// Each stage consumes the top four numerator bits.
		assign step = usg_pkg::div_step(rem_prev, num_prev[31:28], seg);

		always_ff @(posedge clk) begin
			rem_s[k]  <= step[11:4];
			num_s[k]  <= {num_prev[27:0], 4'b0};
			quot_s[k] <= {quot_prev[27:0], step[3:0]};
		end
	end

	assign quot = quot_s[usg_pkg::DIV_STAGES-1];

endmodule

### src/usg_cordic.sv
// Rotation-mode CORDIC, one iteration per stage, followed by a stage that
// maps the quadrant and clamps to one. Outputs are Q1.30.
module usg_cordic (
	input  logic               clk,
	input  logic [31:0]        angle,
	output logic signed [31:0] cos_v,
	output logic signed [31:0] sin_v
);

	logic signed [33:0] x_s    [usg_pkg::CORDIC_ITERS];
	logic signed [33:0] y_s    [usg_pkg::CORDIC_ITERS];
	logic signed [32:0] z_s    [usg_pkg::CORDIC_ITERS];
	logic [1:0]         quad_s [usg_pkg::CORDIC_ITERS];

	for (genvar i = 0; i < usg_pkg::CORDIC_ITERS; i++) begin : g_iter
		logic signed [33:0] x_prev;
		logic signed [33:0] y_prev;
		logic signed [32:0] z_prev;
		logic [1:0]         quad_prev;
		logic signed [32:0] atan_v;

		if (i == 0) begin : g_first
			assign x_prev    = usg_pkg::CORDIC_GAIN;
			assign y_prev    = '0;
			assign z_prev    = $signed({3'b0, angle[29:0]});
			assign quad_prev = angle[31:30];
		end else begin : g_next
			assign x_prev    = x_s[i-1];
			assign y_prev    = y_s[i-1];
			assign z_prev    = z_s[i-1];
			assign quad_prev = quad_s[i-1];
		end

		assign atan_v = $signed({3'b0, usg_pkg::atan_turn(i)});

		// Rotate toward a zero residual angle.
		always_ff @(posedge clk) begin
			if (!z_prev[32]) begin
				x_s[i] <= x_prev - (y_prev >>> i);
				y_s[i] <= y_prev + (x_prev >>> i);
				z_s[i] <= z_prev - atan_v;
			end else begin
				x_s[i] <= x_prev + (y_prev >>> i);
				y_s[i] <= y_prev - (x_prev >>> i);
				z_s[i] <= z_prev + atan_v;
			end
			quad_s[i] <= quad_prev;
		end
	end

	function automatic logic signed [31:0] clamp_one(input logic signed [33:0] v);
		logic signed [33:0] c;
		if (v > usg_pkg::ONE_Q30) begin
			c = usg_pkg::ONE_Q30;
		end else if (v < -usg_pkg::ONE_Q30) begin
			c = -usg_pkg::ONE_Q30;
		end else begin
			c = v;
		end
		return c[31:0];
	endfunction

	logic signed [33:0] x_last;
	logic signed [33:0] y_last;
	logic signed [33:0] c_map;
	logic signed [33:0] s_map;

	assign x_last = x_s[usg_pkg::CORDIC_ITERS-1];
	assign y_last = y_s[usg_pkg::CORDIC_ITERS-1];

	// Quadrant mapping of the residual result.
	always_comb begin
		unique case (quad_s[usg_pkg::CORDIC_ITERS-1])
			2'd0: begin
				c_map = x_last;
				s_map = y_last;
			end
			2'd1: begin
				c_map = -y_last;
				s_map = x_last;
			end
			2'd2: begin
				c_map = -x_last;
				s_map = -y_last;
			end
			default: begin
				c_map = y_last;
				s_map = -x_last;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		cos_v <= clamp_one(c_map);
		sin_v <= clamp_one(s_map);
	end

endmodule

### src/usg_mul.sv
// Products of the trigonometric terms with each other and with the radius,
// rounded half up and clamped. Four register stages.
module usg_mul (
	input  logic               clk,
	input  logic [23:0]        radius,
	input  logic signed [31:0] cos_t,
	input  logic signed [31:0] sin_t,
	input  logic signed [31:0] cos_p,
	input  logic signed [31:0] sin_p,
	output logic signed [24:0] pos_x,
	output logic signed [24:0] pos_y,
	output logic signed [24:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z
);

	function automatic logic signed [24:0] pos_round(input logic signed [57:0] m);
		logic signed [57:0] r;
		logic signed [27:0] n;
		r = (m + 58'sd536870912) >>> 30;
		n = r[27:0];
		if (n > usg_pkg::POS_LIMIT) begin
			n = usg_pkg::POS_LIMIT;
		end else if (n < -usg_pkg::POS_LIMIT) begin
			n = -usg_pkg::POS_LIMIT;
		end
		return n[24:0];
	endfunction

	function automatic logic signed [15:0] norm_round(input logic signed [31:0] v);
		logic signed [32:0] r;
		logic signed [16:0] n;
		r = ($signed({v[31], v}) + 33'sd16384) >>> 15;
		n = r[16:0];
		if (n > usg_pkg::NORM_LIMIT) begin
			n = usg_pkg::NORM_LIMIT;
		end else if (n < -usg_pkg::NORM_LIMIT) begin
			n = -usg_pkg::NORM_LIMIT;
		end
		return n[15:0];
	endfunction

	function automatic logic signed [31:0] q30_round(input logic signed [63:0] p);
		logic signed [63:0] r;
		r = (p + 64'sd536870912) >>> 30;
		return r[31:0];
	endfunction

	logic signed [63:0] psc_s1;
	logic signed [63:0] pss_s1;
	logic signed [31:0] ct_s1;
	logic signed [31:0] sc_s2;
	logic signed [31:0] ss_s2;
	logic signed [31:0] ct_s2;
	logic signed [57:0] mx_s3;
	logic signed [57:0] my_s3;
	logic signed [57:0] mz_s3;
	logic signed [31:0] sc_s3;
	logic signed [31:0] ss_s3;
	logic signed [31:0] ct_s3;
	logic signed [57:0] rad_ext;

	assign rad_ext = $signed({34'b0, radius});

	// Stage one: sin(theta) times cos(phi) and sin(phi).
	always_ff @(posedge clk) begin
		psc_s1 <= $signed({{32{sin_t[31]}}, sin_t}) * $signed({{32{cos_p[31]}}, cos_p});
		pss_s1 <= $signed({{32{sin_t[31]}}, sin_t}) * $signed({{32{sin_p[31]}}, sin_p});
		ct_s1  <= cos_t;
	end

	// Stage two: back to Q1.30.
	always_ff @(posedge clk) begin
		sc_s2 <= q30_round(psc_s1);
		ss_s2 <= q30_round(pss_s1);
		ct_s2 <= ct_s1;
	end

	// Stage three: scale by the radius.
	always_ff @(posedge clk) begin
		mx_s3 <= rad_ext * $signed({{26{sc_s2[31]}}, sc_s2});
		my_s3 <= rad_ext * $signed({{26{ct_s2[31]}}, ct_s2});
		mz_s3 <= rad_ext * $signed({{26{ss_s2[31]}}, ss_s2});
		sc_s3 <= sc_s2;
		ss_s3 <= ss_s2;
		ct_s3 <= ct_s2;
	end

	// Stage four: round and clamp into the result formats.
	always_ff @(posedge clk) begin
		pos_x  <= pos_round(mx_s3);
		pos_y  <= pos_round(my_s3);
		pos_z  <= pos_round(mz_s3);
		norm_x <= norm_round(sc_s3);
		norm_y <= norm_round(ct_s3);
		norm_z <= norm_round(ss_s3);
	end

endmodule
